// ===== rtl/b64lw_pkg.sv =====
// ----------------------------------------------------------------------------
// b64lw_pkg
// Types, character constants and the base64 alphabet for the line-wrapped
// base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam int unsigned MaxChars = 6;

  localparam logic [7:0] CH_PAD = 8'h3D;  // '='
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  localparam logic [2:0] LAST_IDX_GROUP = 3'd3;
  localparam logic [2:0] LAST_IDX_CRLF  = 3'd5;

  // Characters produced by one request.
  typedef struct packed {
    logic                   has_chars;
    logic                   last;
    logic [2:0]             last_idx;
    logic [MaxChars-1:0][7:0] chars;
  } group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] b64_sym(input logic [5:0] idx);
    logic [7:0] wide;
    logic [7:0] ch;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      ch = 8'(wide + 8'h41);
    end else if (idx < 6'd52) begin
      ch = 8'(wide + 8'h47);
    end else if (idx < 6'd62) begin
      ch = 8'(wide - 8'd4);
    end else if (idx == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/b64lw_enc.sv =====
// ----------------------------------------------------------------------------
// b64lw_enc
// Group and line state; turns one accepted byte into the characters it
// causes (none, a four-character group, or a group followed by CR LF).
// ----------------------------------------------------------------------------
module b64lw_enc
  import b64lw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [9:0]  line_len,
  output group_t      grp
);

  logic [15:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_cnt_r,   held_cnt_nxt;
  logic [10:0] line_pos_r,   line_pos_nxt;

  logic [7:0]  b0, b1;
  logic [10:0] pos_sum;

  always_comb begin
    grp           = '0;
    held_bytes_nxt = held_bytes_r;
    held_cnt_nxt   = held_cnt_r;
    line_pos_nxt   = line_pos_r;
    b0            = held_bytes_r[15:8];
    b1            = held_bytes_r[7:0];
    pos_sum       = 11'(line_pos_r + 11'd4);

    if (held_cnt_r == CNT_TWO) begin
      grp.has_chars = 1'b1;
      grp.last_idx  = LAST_IDX_GROUP;
      grp.chars[0]  = b64_sym(b0[7:2]);
      grp.chars[1]  = b64_sym({b0[1:0], b1[7:4]});
      grp.chars[2]  = b64_sym({b1[3:0], data_byte[7:6]});
      grp.chars[3]  = b64_sym(data_byte[5:0]);
      if (line_len != 10'd0) begin
        line_pos_nxt = pos_sum;
        if (pos_sum >= {1'b0, line_len}) begin
          grp.last_idx = LAST_IDX_CRLF;
          grp.chars[4] = CH_CR;
          grp.chars[5] = CH_LF;
          line_pos_nxt = '0;
        end
      end
      held_bytes_nxt = '0;
      held_cnt_nxt   = CNT_NONE;
    end else if (held_cnt_r == CNT_ONE) begin
      held_bytes_nxt = {b0, data_byte};
      held_cnt_nxt   = CNT_TWO;
      if (last_byte) begin
        grp.has_chars = 1'b1;
        grp.last_idx  = LAST_IDX_GROUP;
        grp.chars[0]  = b64_sym(b0[7:2]);
        grp.chars[1]  = b64_sym({b0[1:0], data_byte[7:4]});
        grp.chars[2]  = b64_sym({data_byte[3:0], 2'b00});
        grp.chars[3]  = CH_PAD;
      end
    end else begin
      held_bytes_nxt = {data_byte, 8'h00};
      held_cnt_nxt   = CNT_ONE;
      if (last_byte) begin
        grp.has_chars = 1'b1;
        grp.last_idx  = LAST_IDX_GROUP;
        grp.chars[0]  = b64_sym(data_byte[7:2]);
        grp.chars[1]  = b64_sym({data_byte[1:0], 4'b0000});
        grp.chars[2]  = CH_PAD;
        grp.chars[3]  = CH_PAD;
      end
    end

    // Message end: clear the held bytes and restart the line.
    if (last_byte) begin
      grp.last       = 1'b1;
      held_bytes_nxt = '0;
      held_cnt_nxt   = CNT_NONE;
      line_pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= '0;
      held_cnt_r   <= CNT_NONE;
      line_pos_r   <= '0;
    end else if (in_fire) begin
      held_bytes_r <= held_bytes_nxt;
      held_cnt_r   <= held_cnt_nxt;
      line_pos_r   <= line_pos_nxt;
    end
  end

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_byte |=> held_cnt_r == CNT_NONE && line_pos_r == '0)
    else $error("state not cleared after message end");

  a_last_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_byte |-> grp.has_chars)
    else $error("message end produced no characters");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd3)
    else $error("held byte count out of range");
`endif

endmodule

// ===== rtl/base64_line_wrapped_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top
// Streaming base64 encoder with optional CR LF line wrapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per request,
//   with in_last_byte marking the final byte. Output channel
//   (out_valid/out_ready) carries one character per request; out_last_char
//   marks the final character of the message.
//   Configuration channel (cfg_valid/cfg_ready) writes the line length;
//   cfg_ready is always high. 0 disables wrapping. Write only while idle.
// Output: the characters of an accepted byte are registered in the character
//   buffer and appear on the output in the cycle after the byte is accepted.
// Input: a byte that causes no characters does not fill the buffer, so the next byte can follow it directly.
//   A byte that closes a group fills the character buffer with 4 or 6
//   characters, sent one per cycle while out_ready is high; the next byte
//   is accepted in the same cycle as the last of them is taken.
// Reset: clears the group, the line position, the line length and the
//   buffer's busy flag and character index.
// Stall: while out_ready is low the current character holds and in_ready
//   stays low if the buffer is occupied.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_top
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_char,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_line_length
);

  logic [9:0] line_len_r;
  group_t     grp;
  group_t     buf_r;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       in_fire, out_fire, drain_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      line_len_r <= cfg_line_length;
    end
  end

  b64lw_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .line_len  (line_len_r),
    .grp       (grp)
  );

  assign out_valid     = busy_r;
  assign out_char      = buf_r.chars[idx_r];
  assign out_last_char = buf_r.last && (idx_r == buf_r.last_idx);
  assign out_fire      = out_valid && out_ready;
  assign drain_last    = out_fire && (idx_r == buf_r.last_idx);
  assign in_ready      = !busy_r || drain_last;
  assign in_fire       = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (in_fire && grp.has_chars) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (drain_last) begin
      busy_nxt = 1'b0;
      idx_nxt  = '0;
    end else if (out_fire) begin
      idx_nxt  = 3'(idx_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && grp.has_chars) begin
      buf_r <= grp;
    end
  end

`ifndef SYNTH
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= buf_r.last_idx)
    else $error("character index past end of group");

  a_group_len: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (buf_r.last_idx == LAST_IDX_GROUP || buf_r.last_idx == LAST_IDX_CRLF))
    else $error("bad group length");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last_char))
    else $error("output request changed while stalled");
`endif

endmodule

// ===== tb/sv/base64_line_wrapped_encoder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_top_tb
// Self-checking bench for the streaming base64 encoder with CR LF wrapping.
// A queue-fed driver sends message bytes. Each accepted byte runs through a
// local encoder model that queues the characters it should produce. A
// monitor checks every character and its end flag against that queue. The
// line length changes between phases, and both sides idle at random.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_top_tb
  import b64lw_pkg::*;
();

  localparam int PAUSE_CYCLES = 200;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last_char;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_line_length = 10'd0;

  // Encoder model state
  logic [15:0] held_bytes = 16'h0000;
  logic [1:0]  held_cnt = CNT_NONE;
  logic [10:0] line_pos = 11'd0;
  logic [9:0]  line_len = 10'd0;

  byte_req_t bytes_pending[$];
  char_t     chars_due[$];

  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic pause_armed = 1'b0;
  logic pause_done;
  int   tx_gap;
  int   rx_stall;
  int   rx_pause;

  int errors = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int cfg_writes = 0;

  int unsigned wrap_set [6] = '{0, 1023, 76, 8, 3, 1};

  base64_line_wrapped_encoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_length(cfg_line_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    string alpha;
    alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alpha[idx];
  endfunction

  // Advance the encoder model by one byte and queue the characters it yields.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] seq [6];
    int         n;
    int         k;
    char_t      c;
    n = 0;
    if (held_cnt == CNT_TWO) begin
      b0 = held_bytes[15:8];
      b1 = held_bytes[7:0];
      seq[0] = b64_char(b0[7:2]);
      seq[1] = b64_char({b0[1:0], b1[7:4]});
      seq[2] = b64_char({b1[3:0], b[7:6]});
      seq[3] = b64_char(b[5:0]);
      n = 4;
      if (line_len != 10'd0) begin
        line_pos = line_pos + 11'd4;
        if (line_pos >= {1'b0, line_len}) begin
          seq[4] = CH_CR;
          seq[5] = CH_LF;
          n = 6;
          line_pos = 11'd0;
        end
      end
      held_bytes = 16'h0000;
      held_cnt = CNT_NONE;
    end else if (held_cnt == CNT_ONE) begin
      held_bytes[7:0] = b;
      held_cnt = CNT_TWO;
    end else begin
      held_bytes = {b, 8'h00};
      held_cnt = CNT_ONE;
    end

    if (last) begin
      b0 = held_bytes[15:8];
      b1 = held_bytes[7:0];
      if (held_cnt == CNT_ONE) begin
        seq[0] = b64_char(b0[7:2]);
        seq[1] = b64_char({b0[1:0], 4'b0000});
        seq[2] = CH_PAD;
        seq[3] = CH_PAD;
        n = 4;
      end else if (held_cnt == CNT_TWO) begin
        seq[0] = b64_char(b0[7:2]);
        seq[1] = b64_char({b0[1:0], b1[7:4]});
        seq[2] = b64_char({b1[3:0], 2'b00});
        seq[3] = CH_PAD;
        n = 4;
      end
      held_bytes = 16'h0000;
      held_cnt = CNT_NONE;
      line_pos = 11'd0;
    end

    for (k = 0; k < n; k++) begin
      c.ch = seq[k];
      c.last = last && (k == n - 1);
      chars_due.push_back(c);
    end
  endtask

  task automatic report_error(input string msg);
    if (errors < 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Driver: present pending bytes, hold each until taken, then idle a while.
  always @(posedge clk) begin
    logic      take;
    int        gap_now;
    byte_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      take = in_valid && in_ready;
      gap_now = tx_gap;
      if (take) begin
        encode_byte(in_data_byte, in_last_byte);
        bytes_sent++;
        gap_now = tx_burst ? 0 : $urandom_range(0, 9);
      end
      if (in_valid && !take) begin
        // hold the request
      end else if (gap_now > 0) begin
        in_valid <= 1'b0;
        tx_gap <= gap_now - 1;
      end else if (bytes_pending.size() > 0) begin
        req = bytes_pending.pop_front();
        in_data_byte <= req.data;
        in_last_byte <= req.last;
        in_valid <= 1'b1;
        tx_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        tx_gap <= 0;
      end
    end
  end

  // Monitor: check each character, then stall the output for a while.
  always @(posedge clk) begin
    logic  took;
    int    stall_now;
    char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
      rx_pause <= 0;
      pause_done <= 1'b0;
    end else begin
      took = out_valid && out_ready;
      stall_now = rx_stall;
      if (took) begin
        chars_checked++;
        if (chars_due.size() == 0) begin
          report_error($sformatf("unexpected char 0x%02h last %0b", out_char, out_last_char));
        end else begin
          want = chars_due.pop_front();
          if (out_char !== want.ch) begin
            report_error($sformatf("out_char expected 0x%02h got 0x%02h", want.ch, out_char));
          end
          if (out_last_char !== want.last) begin
            report_error($sformatf("out_last_char expected %0b got %0b",
                                   want.last, out_last_char));
          end
        end
        stall_now = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (rx_pause > 0) begin
        out_ready <= 1'b0;
        rx_pause <= rx_pause - 1;
      end else if (pause_armed && !pause_done) begin
        // hold off long enough for the encoder to back up into its input
        out_ready <= 1'b0;
        rx_pause <= PAUSE_CYCLES;
        pause_done <= 1'b1;
      end else if (stall_now > 0) begin
        out_ready <= 1'b0;
        rx_stall <= stall_now - 1;
      end else begin
        out_ready <= 1'b1;
        rx_stall <= 0;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last);
    byte_req_t req;
    req.data = b;
    req.last = last;
    bytes_pending.push_back(req);
  endtask

  // Mostly whole messages with random content; now and then drop the end
  // flag, and cut the final message short when the budget runs out.
  task automatic queue_messages(input int n_items);
    int         len;
    int         k;
    logic [7:0] b;
    while (n_items > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (k = 0; k < len && n_items > 0; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        queue_byte(b, (k == len - 1) && ($urandom_range(0, 19) != 0));
        n_items--;
      end
    end
  endtask

  // Sample at the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_pending.size() != 0 || in_valid || chars_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_length(input logic [9:0] v);
    cfg_valid <= 1'b1;
    cfg_line_length <= v;
    do @(posedge clk);
    while (!cfg_ready);
    line_len = v;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Wrapping off after reset: one- and two-byte padding, '+' and '/' groups
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    wait_idle();

    // Wrap every group, including one closed by the last byte
    write_line_length(10'd4);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    wait_idle();

    // Build up a line position, then lower the length below it mid-message
    write_line_length(10'd1023);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h9A, 1'b0);
    queue_byte(8'hBC, 1'b0);
    wait_idle();
    write_line_length(10'd5);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h01, 1'b1);
    wait_idle();

    // Padded endings never wrap
    write_line_length(10'd1);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h01, 1'b1);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      write_line_length(10'(wrap_set[p]));
      tx_burst <= (p == 3);
      rx_burst <= (p == 3);
      queue_messages(18);
      wait_idle();
    end

    // Back-pressure: sender streams while the receiver pauses
    write_line_length(10'($urandom_range(1, 60)));
    tx_burst <= 1'b1;
    rx_burst <= 1'b0;
    pause_armed <= 1'b1;
    queue_messages(40);
    wait_idle();

    $display("covered %0d bytes and %0d characters over %0d line length settings",
             bytes_sent, chars_checked, cfg_writes);
    $display("includes a %0d-cycle output pause with the input streaming", PAUSE_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d characters still due", chars_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
